>>> design/dbam_pkg.sv
// ----------------------------------------------------------------------------
// dbam_pkg
// Shared types, constants and zone functions for the block allocation map.
// ----------------------------------------------------------------------------
package dbam_pkg;

   localparam int MAX_TRACKS    = 40;
   localparam int NUM_TRACKS_DEF = 35;
   localparam int DIR_TRACK_DEF  = 18;
   localparam int MAP_BITS      = 21;
   localparam int COUNT_BITS    = 8;
   localparam int TRACK_BITS    = 6;
   localparam int SECTOR_BITS   = 5;
   localparam int TOTAL_BITS    = 10;

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_FORMAT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [MAP_BITS-1:0]   map;
      logic [COUNT_BITS-1:0] count;
   } row_type;

   typedef struct packed {
      logic [TRACK_BITS-1:0] trk;
      logic                  ok;
      logic                  done;
   } cand_type;

   // sectors per track by zone
   function automatic logic [SECTOR_BITS-1:0] spt(input logic [7:0] t, input int num);
      logic [SECTOR_BITS-1:0] n;
      n = '0;
      if (t >= 8'd1 && t <= 8'd17) begin
         n = 5'd21;
      end else if (t >= 8'd18 && t <= 8'd24) begin
         n = 5'd19;
      end else if (t >= 8'd25 && t <= 8'd30) begin
         n = 5'd18;
      end else if (t >= 8'd31 && t <= 8'(num)) begin
         n = 5'd17;
      end
      return n;
   endfunction

   function automatic logic [MAP_BITS-1:0] map_mask(input logic [SECTOR_BITS-1:0] n);
      logic [MAP_BITS-1:0] m;
      for (int i = 0; i < MAP_BITS; i++) begin
         m[i] = (5'(i) < n);
      end
      return m;
   endfunction

   function automatic row_type fmt_row(input logic [7:0] t, input int num, input int dir);
      row_type                r;
      logic [SECTOR_BITS-1:0] n;
      n       = spt(t, num);
      r.map   = map_mask(n);
      r.count = {3'b000, n};
      if (t == 8'(dir)) begin
         r.map[1:0] = 2'b00;
         r.count    = r.count - 8'd2;
      end
      return r;
   endfunction

   function automatic int fmt_total(input int num, input int dir);
      int total;
      total = 0;
      for (int t = 1; t <= MAX_TRACKS; t++) begin
         if (t <= num && t != dir) begin
            total = total + int'(spt(8'(t), num));
         end
      end
      return total;
   endfunction

   // lowest set bit of a free map
   function automatic logic [SECTOR_BITS-1:0] lowest_free(input logic [MAP_BITS-1:0] m);
      logic [SECTOR_BITS-1:0] s;
      s = '0;
      for (int i = MAP_BITS - 1; i >= 0; i--) begin
         if (m[i]) begin
            s = 5'(i);
         end
      end
      return s;
   endfunction

endpackage

>>> design/dbam_row_store.sv
// ----------------------------------------------------------------------------
// dbam_row_store
// Track row memory with a registered read; per-row valid bits make a
// row that was not written since format read as its formatted value.
// ----------------------------------------------------------------------------
module dbam_row_store #(
   parameter int NUM_TRACKS = dbam_pkg::NUM_TRACKS_DEF,
   parameter int DIR_TRACK  = dbam_pkg::DIR_TRACK_DEF,
   parameter int AW         = $clog2(NUM_TRACKS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear_all,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  dbam_pkg::row_type wr_row,
   output dbam_pkg::row_type rd_row
);
   import dbam_pkg::*;

   row_type                 mem [NUM_TRACKS];
   logic [NUM_TRACKS-1:0]   vld_ff, vld_in;
   row_type                 rd_data_ff;
   logic                    rd_hit_ff;
   logic [AW-1:0]           rd_addr_ff;

   always_comb begin
      vld_in = vld_ff;
      if (clear_all) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= vld_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   assign rd_row = rd_hit_ff ? rd_data_ff
                             : fmt_row(8'(rd_addr_ff) + 8'd1, NUM_TRACKS, DIR_TRACK);

   a_no_wr_on_clear : assert property (@(posedge clock) disable iff (reset)
      clear_all |-> !wr_en && !rd_en)
      else $error("row write or read during format");

   a_no_rw_collision : assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> rd_addr != wr_addr)
      else $error("read and write of the same row in one cycle");

endmodule

>>> design/dbam_spiral.sv
// ----------------------------------------------------------------------------
// dbam_spiral
// Candidate track sequencer for allocation: preferred track, then outward
// from the directory track, lower side before upper side.
// ----------------------------------------------------------------------------
module dbam_spiral #(
   parameter int NUM_TRACKS = dbam_pkg::NUM_TRACKS_DEF,
   parameter int DIR_TRACK  = dbam_pkg::DIR_TRACK_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [7:0]         pref_track,
   input  logic               advance,
   output dbam_pkg::cand_type cand
);
   import dbam_pkg::*;

   localparam int DMAX = (DIR_TRACK - 1 > NUM_TRACKS - DIR_TRACK) ?
                         DIR_TRACK - 1 : NUM_TRACKS - DIR_TRACK;

   logic       pref_ff, pref_in;
   logic       high_ff, high_in;
   logic       done_ff, done_in;
   logic [5:0] d_ff, d_in;
   logic [7:0] pref_trk_ff, pref_trk_in;
   logic [6:0] d_next;
   logic [6:0] lo_trk, hi_trk;
   logic       pref_ok;

   assign d_next  = {1'b0, d_ff} + 7'd1;
   assign lo_trk  = 7'(DIR_TRACK) - {1'b0, d_ff};
   assign hi_trk  = 7'(DIR_TRACK) + {1'b0, d_ff};
   assign pref_ok = pref_trk_ff >= 8'd1 && pref_trk_ff <= 8'(NUM_TRACKS)
                    && pref_trk_ff != 8'(DIR_TRACK);

   always_comb begin
      if (pref_ff) begin
         cand.trk = pref_trk_ff[5:0];
      end else if (high_ff) begin
         cand.trk = hi_trk[5:0];
      end else begin
         cand.trk = lo_trk[5:0];
      end
      cand.ok   = !done_ff && (!pref_ff || pref_ok);
      cand.done = done_ff;
   end

   always_comb begin
      pref_in     = pref_ff;
      high_in     = high_ff;
      done_in     = done_ff;
      d_in        = d_ff;
      pref_trk_in = pref_trk_ff;
      if (load) begin
         pref_in     = 1'b1;
         high_in     = 1'b0;
         done_in     = 1'b0;
         d_in        = 6'd1;
         pref_trk_in = pref_track;
      end else if (advance && !done_ff) begin
         priority if (pref_ff) begin
            pref_in = 1'b0;
            d_in    = 6'd1;
            high_in = !(DIR_TRACK > 1);
         end else if (!high_ff && hi_trk <= 7'(NUM_TRACKS)) begin
            high_in = 1'b1;
         end else if (d_next > 7'(DMAX)) begin
            done_in = 1'b1;
         end else begin
            d_in    = d_next[5:0];
            high_in = !(d_next < 7'(DIR_TRACK));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pref_ff <= 1'b0;
         high_ff <= 1'b0;
         done_ff <= 1'b1;
         d_ff    <= 6'd1;
      end else begin
         pref_ff <= pref_in;
         high_ff <= high_in;
         done_ff <= done_in;
         d_ff    <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      pref_trk_ff <= pref_trk_in;
   end

   a_cand_in_range : assert property (@(posedge clock) disable iff (reset)
      cand.ok |-> cand.trk != 6'(DIR_TRACK) && cand.trk >= 6'd1
                  && cand.trk <= 6'(NUM_TRACKS))
      else $error("allocation candidate outside usable tracks");

endmodule

>>> design/disk_block_allocation_map_core.sv
// ----------------------------------------------------------------------------
// disk_block_allocation_map_core
// Block allocation map: allocate, free, query and format over track rows.
// ----------------------------------------------------------------------------
// One command at a time: a transfer happens when start is high and busy is
// low, and exactly one result follows, shown for a single cycle with
// rsp_strobe; the receiver cannot stall it. Format marks every row as
// formatted and answers; free and query check the track and sector first
// and answer without a row read when either is invalid. Allocate reads one
// track row per cycle from the single read port of the row memory, in order
// preferred track, then outward from the directory track, and answers as
// soon as a track has room or no candidate is left. The map is in the
// formatted state right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module disk_block_allocation_map_core #(
   parameter int NUM_TRACKS = dbam_pkg::NUM_TRACKS_DEF,
   parameter int DIR_TRACK  = dbam_pkg::DIR_TRACK_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_track,
   input  logic [7:0] req_sector,
   output logic       rsp_strobe,
   output logic       rsp_status,
   output logic [5:0] rsp_got_track,
   output logic [4:0] rsp_got_sector,
   output logic       rsp_is_used,
   output logic [9:0] rsp_free_blocks
);
   import dbam_pkg::*;

   localparam int              AW        = $clog2(NUM_TRACKS);
   localparam logic [9:0]      FMT_TOTAL = 10'(fmt_total(NUM_TRACKS, DIR_TRACK));

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_MODIFY = 5'b00100,
      ST_ALLOC  = 5'b01000,
      ST_FORMAT = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] trk_ff, trk_in;
   logic [7:0] sec_ff, sec_in;
   logic [9:0] total_ff, total_in;
   logic       pend_ff, pend_in;
   logic [5:0] pend_trk_ff, pend_trk_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   logic       rsp_status_ff, rsp_status_in;
   logic [5:0] rsp_got_track_ff, rsp_got_track_in;
   logic [4:0] rsp_got_sector_ff, rsp_got_sector_in;
   logic       rsp_is_used_ff, rsp_is_used_in;
   logic [9:0] rsp_free_ff, rsp_free_in;

   logic          clear_all, rd_en, wr_en, sp_load, sp_advance;
   logic [AW-1:0] rd_addr, wr_addr;
   row_type       wr_row, rd_row;
   cand_type      cand;

   logic                ts_valid, sbit, hit;
   logic [7:0]          trk_m1;
   logic [5:0]          pend_m1, cand_m1;
   logic [MAP_BITS-1:0] avail;
   logic [4:0]          low_sec;

   dbam_row_store #(
      .NUM_TRACKS (NUM_TRACKS),
      .DIR_TRACK  (DIR_TRACK),
      .AW         (AW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_row    (wr_row),
      .rd_row    (rd_row)
   );

   dbam_spiral #(
      .NUM_TRACKS (NUM_TRACKS),
      .DIR_TRACK  (DIR_TRACK)
   ) u_spiral (
      .clock      (clock),
      .reset      (reset),
      .load       (sp_load),
      .pref_track (req_track),
      .advance    (sp_advance),
      .cand       (cand)
   );

   assign trk_m1   = trk_ff - 8'd1;
   assign pend_m1  = pend_trk_ff - 6'd1;
   assign cand_m1  = cand.trk - 6'd1;
   assign ts_valid = trk_ff >= 8'd1 && trk_ff <= 8'(NUM_TRACKS)
                     && sec_ff < {3'b000, spt(trk_ff, NUM_TRACKS)};
   assign sbit     = rd_row.map[sec_ff[4:0]];
   assign avail    = rd_row.map & map_mask(spt({2'b00, pend_trk_ff}, NUM_TRACKS));
   assign hit      = pend_ff && rd_row.count != 8'd0 && avail != '0;
   assign low_sec  = lowest_free(avail);

   always_comb begin
      state_in          = state_ff;
      kind_in           = kind_ff;
      trk_in            = trk_ff;
      sec_in            = sec_ff;
      total_in          = total_ff;
      pend_in           = 1'b0;
      pend_trk_in       = cand.trk;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = 1'b0;
      rsp_got_track_in  = '0;
      rsp_got_sector_in = '0;
      rsp_is_used_in    = 1'b0;
      clear_all         = 1'b0;
      rd_en             = 1'b0;
      rd_addr           = trk_m1[AW-1:0];
      wr_en             = 1'b0;
      wr_addr           = trk_m1[AW-1:0];
      wr_row            = rd_row;
      sp_load           = 1'b0;
      sp_advance        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = kind_type'(req_kind);
               trk_in  = req_track;
               sec_in  = req_sector;
               sp_load = 1'b1;
               unique case (kind_type'(req_kind))
                  KIND_ALLOC:  state_in = ST_ALLOC;
                  KIND_FREE:   state_in = ST_CHECK;
                  KIND_QUERY:  state_in = ST_CHECK;
                  KIND_FORMAT: state_in = ST_FORMAT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK: begin
            if (!ts_valid) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = 1'b1;
               rsp_is_used_in = (kind_ff == KIND_QUERY);
               state_in       = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (kind_ff == KIND_FREE) begin
               if (!sbit) begin
                  wr_en                    = 1'b1;
                  wr_row.map[sec_ff[4:0]]  = 1'b1;
                  wr_row.count             = rd_row.count + 8'd1;
                  if (trk_ff != 8'(DIR_TRACK)) begin
                     total_in = total_ff + 10'd1;
                  end
               end
            end else begin
               rsp_is_used_in = !sbit;
            end
         end
         ST_ALLOC: begin
            sp_advance = 1'b1;
            if (hit) begin
               wr_en             = 1'b1;
               wr_addr           = pend_m1[AW-1:0];
               wr_row.map[low_sec] = 1'b0;
               wr_row.count      = rd_row.count - 8'd1;
               total_in          = total_ff - 10'd1;
               rsp_strobe_in     = 1'b1;
               rsp_got_track_in  = pend_trk_ff;
               rsp_got_sector_in = low_sec;
               state_in          = ST_IDLE;
            end else if (cand.done) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rd_en   = cand.ok;
               rd_addr = cand_m1[AW-1:0];
               pend_in = cand.ok;
            end
         end
         ST_FORMAT: begin
            clear_all     = 1'b1;
            total_in      = FMT_TOTAL;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_free_in = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= FMT_TOTAL;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff           <= kind_in;
      trk_ff            <= trk_in;
      sec_ff            <= sec_in;
      pend_trk_ff       <= pend_trk_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_got_track_ff  <= rsp_got_track_in;
      rsp_got_sector_ff <= rsp_got_sector_in;
      rsp_is_used_ff    <= rsp_is_used_in;
      rsp_free_ff       <= rsp_free_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_got_track   = rsp_got_track_ff;
   assign rsp_got_sector  = rsp_got_sector_ff;
   assign rsp_is_used     = rsp_is_used_ff;
   assign rsp_free_blocks = rsp_free_ff;

   a_done_gives_result : assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("command finished without a result transfer");

   a_result_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result transfer while a command is still running");

   a_alloc_track_usable : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_got_track != 6'd0) |->
         rsp_got_track != 6'(DIR_TRACK) && rsp_got_track <= 6'(NUM_TRACKS)
         && !rsp_status)
      else $error("allocation returned an unusable track");

endmodule
